>>> rtl/ebd_pkg.sv
`default_nettype none
package ebd_pkg;

	localparam int unsigned TIME_BITS = 32;
	localparam int unsigned LONG_BITS = 16;
	localparam int unsigned OUT_COUNT_BITS = 16;

	localparam logic [LONG_BITS-1:0] LONG_PRESS_RESET = 16'd300;

	// accumulator thresholds for one detent
	localparam logic signed [3:0] ACC_UP = 4'sd2;
	localparam logic signed [3:0] ACC_DOWN = -4'sd2;

	// pin positions within the sampled pin vector
	localparam int unsigned PIN_A = 0;
	localparam int unsigned PIN_B = 1;
	localparam int unsigned PIN_ENC = 2;
	localparam int unsigned PIN_BACK = 3;

	// step for index {previous phase, new phase}, phase = {a, b}
	localparam logic signed [3:0] PHASE_STEP [16] = '{
		4'sd0, -4'sd1, 4'sd1, 4'sd0,
		4'sd1, 4'sd0, 4'sd0, -4'sd1,
		-4'sd1, 4'sd0, 4'sd0, 4'sd1,
		4'sd0, 4'sd1, -4'sd1, 4'sd0
	};

	typedef struct packed {
		logic                 clear_events;
		logic                 clear_count;
		logic [TIME_BITS-1:0] time_ms;
		logic [3:0]           pins;
	} ebd_item_t;

	typedef struct packed {
		logic [3:0]                pin_levels;
		logic                      back_long;
		logic                      enc_long;
		logic                      back_short;
		logic                      enc_short;
		logic                      back_held;
		logic                      enc_held;
		logic [OUT_COUNT_BITS-1:0] detent_count;
	} ebd_result_t;

endpackage
`default_nettype wire

>>> rtl/ebd_update.sv
`default_nettype none
module ebd_update #(
	parameter int unsigned COUNT_WIDTH = 16,
	parameter int unsigned TIME_WIDTH = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire ebd_pkg::ebd_item_t         item,
	input  wire logic [ebd_pkg::LONG_BITS-1:0] long_press_ms,
	output ebd_pkg::ebd_result_t            result
);

	logic [3:0]             prev_pins_q;
	logic [1:0]             prev_phase_q;
	logic signed [3:0]      acc_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [TIME_WIDTH-1:0]  enc_press_q;
	logic [TIME_WIDTH-1:0]  back_press_q;
	// enc_short, back_short, enc_long, back_long from bit 0 up
	logic [3:0]             events_q;

	logic [3:0]             rising;
	logic [3:0]             falling;
	logic [TIME_WIDTH-1:0]  now;
	logic [TIME_WIDTH-1:0]  enc_held_time;
	logic [TIME_WIDTH-1:0]  back_held_time;
	logic                   enc_is_long;
	logic                   back_is_long;
	logic [3:0]             events_new;
	logic [1:0]             phase;
	logic signed [3:0]      acc_sum;
	logic [COUNT_WIDTH-1:0] count_new;
	logic signed [COUNT_WIDTH-1:0] count_signed;
	logic signed [31:0]     count_ext;

	assign now = item.time_ms[TIME_WIDTH-1:0];
	assign rising = ~prev_pins_q & item.pins;
	assign falling = prev_pins_q & ~item.pins;

	// wrapping held time, press time is the stored one on a release
	assign enc_held_time = now - enc_press_q;
	assign back_held_time = now - back_press_q;
	assign enc_is_long = 32'(enc_held_time) >= 32'(long_press_ms);
	assign back_is_long = 32'(back_held_time) >= 32'(long_press_ms);

	assign events_new = events_q | {
		rising[ebd_pkg::PIN_BACK] & back_is_long,
		rising[ebd_pkg::PIN_ENC] & enc_is_long,
		rising[ebd_pkg::PIN_BACK] & ~back_is_long,
		rising[ebd_pkg::PIN_ENC] & ~enc_is_long
	};

	assign phase = {item.pins[ebd_pkg::PIN_A], item.pins[ebd_pkg::PIN_B]};
	assign acc_sum = 4'(acc_q + ebd_pkg::PHASE_STEP[{prev_phase_q, phase}]);

	always_comb begin
		count_new = count_q;
		if (phase != 2'b00) begin
			if (acc_sum >= ebd_pkg::ACC_UP) begin
				count_new = count_q + COUNT_WIDTH'(1);
			end else if (acc_sum <= ebd_pkg::ACC_DOWN) begin
				count_new = count_q - COUNT_WIDTH'(1);
			end
		end
	end

	assign count_signed = count_new;
	assign count_ext = 32'(count_signed);

	always_comb begin
		result.detent_count = count_ext[ebd_pkg::OUT_COUNT_BITS-1:0];
		result.enc_held = ~item.pins[ebd_pkg::PIN_ENC];
		result.back_held = ~item.pins[ebd_pkg::PIN_BACK];
		result.enc_short = events_new[0];
		result.back_short = events_new[1];
		result.enc_long = events_new[2];
		result.back_long = events_new[3];
		result.pin_levels = item.pins;
	end

	// clears take effect after the result has been formed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pins_q <= '0;
			prev_phase_q <= '0;
			acc_q <= '0;
			count_q <= '0;
			enc_press_q <= '0;
			back_press_q <= '0;
			events_q <= '0;
		end else if (step) begin
			prev_pins_q <= item.pins;
			prev_phase_q <= phase;
			acc_q <= (phase != 2'b00) ? 4'sd0 : acc_sum;
			count_q <= item.clear_count ? '0 : count_new;
			events_q <= item.clear_events ? 4'b0000 : events_new;
			if (falling[ebd_pkg::PIN_ENC]) begin
				enc_press_q <= now;
			end
			if (falling[ebd_pkg::PIN_BACK]) begin
				back_press_q <= now;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/encoder_and_button_press_decoder_unit.sv
// flow: an accepted request is held in the input register, then its result in the result
//   register, which raises m_tvalid until the result is taken
// throughput: one request per cycle unless m_tready stalls the result register, set by the state update
//   between the input register and the result register
// reset: arst_n clears all decoder state and both valid flags at once,
//   long_press_ms returns to 300; both buttons count as pressed after reset
`default_nettype none
module encoder_and_button_press_decoder_unit #(
	parameter int unsigned COUNT_WIDTH = 16,
	parameter int unsigned TIME_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// enc_a, enc_b, enc_button_n, back_button_n, time_ms[31:0], clear_count,
	// clear_events, zero pad
	input  wire logic [39:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// detent_count[15:0], enc_held, back_held, enc_short, back_short,
	// enc_long, back_long, pin_levels[3:0], zero pad
	output logic [31:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);

	logic                        valid_s1;
	ebd_pkg::ebd_item_t          item_s1;
	logic                        valid_s2;
	ebd_pkg::ebd_result_t        result_s2;
	ebd_pkg::ebd_result_t        result;
	logic [ebd_pkg::LONG_BITS-1:0] long_press_q;
	logic                        advance;
	logic                        step;

	assign advance = ~valid_s2 | m_tready;
	assign s_tready = ~valid_s1 | advance;
	assign step = valid_s1 & advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= ebd_pkg::LONG_PRESS_RESET;
		end else if (cfg_we) begin
			long_press_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready & s_tvalid) begin
			item_s1.pins <= s_tdata[3:0];
			item_s1.time_ms <= s_tdata[35:4];
			item_s1.clear_count <= s_tdata[36];
			item_s1.clear_events <= s_tdata[37];
		end
		if (step) begin
			result_s2 <= result;
		end
	end

	ebd_update #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.TIME_WIDTH(TIME_WIDTH)
	) u_update (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.item(item_s1),
		.long_press_ms(long_press_q),
		.result(result)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata = {6'b000000, result_s2};

endmodule
`default_nettype wire

>>> rtl/ebd_checker.sv
`default_nettype none
module ebd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// held flags mirror the reported button pins
	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16] == !m_tdata[24]) && (m_tdata[17] == !m_tdata[25]))
		else $error("held flags disagree with pin levels");

	// a fresh result follows an earlier accepted request
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a request");

	// with the result register empty the input side never stalls
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind encoder_and_button_press_decoder_unit ebd_checker u_ebd_checker (.*);
`default_nettype wire

>>> tb/sv/tb_encoder_and_button_press_decoder_unit.sv
module tb_encoder_and_button_press_decoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int LONG_HOLD = 300;

	// event bit positions
	localparam int EV_ENC_HELD = 0;
	localparam int EV_BACK_HELD = 1;
	localparam int EV_ENC_SHORT = 2;
	localparam int EV_BACK_SHORT = 3;
	localparam int EV_ENC_LONG = 4;
	localparam int EV_BACK_LONG = 5;

	// step per {previous phase, new phase}, phase = {a, b}
	localparam int GRAY_STEP [16] = '{
		0, -1, 1, 0,
		1, 0, 0, -1,
		-1, 0, 0, 1,
		0, 1, -1, 0
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	encoder_and_button_press_decoder_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	ebd_pkg::ebd_item_t   sample_queue [$];
	ebd_pkg::ebd_result_t awaited_reports [$];

	// decoder copy
	logic [15:0]        long_ms = ebd_pkg::LONG_PRESS_RESET;
	logic [3:0]         prev_pins = '0;
	logic [1:0]         prev_phase = '0;
	logic signed [3:0]  step_acc = '0;
	logic [15:0]        detents = '0;
	logic [31:0]        enc_press_at = '0;
	logic [31:0]        back_press_at = '0;
	logic [5:0]         event_bits = '0;

	int errors = 0;
	int reports_checked = 0;
	int short_presses = 0;
	int long_presses = 0;
	int idle_odds = 4;
	int holds_asked = 0;
	int unsigned cycle_count = 0;

	// stimulus generator state
	logic [1:0]  gen_phase = '0;
	logic        gen_enc_n = 1'b1;
	logic        gen_back_n = 1'b1;
	logic        gen_ccw = 1'b0;
	logic [31:0] gen_ms = '0;

	function automatic ebd_pkg::ebd_result_t decode_sample(ebd_pkg::ebd_item_t s);
		logic [3:0]  rise;
		logic [3:0]  fall;
		logic [1:0]  ph;
		logic [31:0] held;
		int          acc;
		ebd_pkg::ebd_result_t r;
		rise = ~prev_pins & s.pins;
		fall = prev_pins & ~s.pins;
		if (fall[ebd_pkg::PIN_ENC])
			enc_press_at = s.time_ms;
		if (fall[ebd_pkg::PIN_BACK])
			back_press_at = s.time_ms;
		event_bits[EV_ENC_HELD] = !s.pins[ebd_pkg::PIN_ENC];
		event_bits[EV_BACK_HELD] = !s.pins[ebd_pkg::PIN_BACK];
		if (rise[ebd_pkg::PIN_ENC]) begin
			held = s.time_ms - enc_press_at;
			if (held < 32'(long_ms)) begin
				event_bits[EV_ENC_SHORT] = 1'b1;
				short_presses++;
			end else begin
				event_bits[EV_ENC_LONG] = 1'b1;
				long_presses++;
			end
		end
		if (rise[ebd_pkg::PIN_BACK]) begin
			held = s.time_ms - back_press_at;
			if (held < 32'(long_ms)) begin
				event_bits[EV_BACK_SHORT] = 1'b1;
				short_presses++;
			end else begin
				event_bits[EV_BACK_LONG] = 1'b1;
				long_presses++;
			end
		end
		ph = {s.pins[ebd_pkg::PIN_A], s.pins[ebd_pkg::PIN_B]};
		acc = int'(step_acc) + GRAY_STEP[{prev_phase, ph}];
		// steps only build up while resting at phase zero
		if (ph != 2'd0) begin
			if (acc >= 2)
				detents++;
			if (acc <= -2)
				detents--;
			acc = 0;
		end
		step_acc = 4'(acc);
		prev_phase = ph;
		prev_pins = s.pins;
		r.detent_count = detents;
		r.enc_held = event_bits[EV_ENC_HELD];
		r.back_held = event_bits[EV_BACK_HELD];
		r.enc_short = event_bits[EV_ENC_SHORT];
		r.back_short = event_bits[EV_BACK_SHORT];
		r.enc_long = event_bits[EV_ENC_LONG];
		r.back_long = event_bits[EV_BACK_LONG];
		r.pin_levels = s.pins;
		// clears land after the report
		if (s.clear_count)
			detents = '0;
		if (s.clear_events)
			event_bits[5:2] = '0;
		return r;
	endfunction

	function automatic void check_field(string what, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			errors++;
		end
	endfunction

	// request driver
	ebd_pkg::ebd_item_t on_bus;
	int send_gap = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				awaited_reports.push_back(decode_sample(on_bus));
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (idle_odds != 0 && sample_queue.size() != 0 &&
						$urandom_range(0, idle_odds) == 0) begin
					send_gap = $urandom_range(0, 4);
					s_tvalid <= 1'b0;
				end else if (sample_queue.size() != 0) begin
					on_bus = sample_queue.pop_front();
					s_tdata <= {2'b00, on_bus};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver readiness, with the long hold-off counted here
	int hold_left = 0;
	int holds_done = 0;
	int stall_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (holds_done != holds_asked) begin
			holds_done++;
			hold_left = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
			stall_left = $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result monitor
	ebd_pkg::ebd_result_t got_report;
	ebd_pkg::ebd_result_t want_report;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_report = ebd_pkg::ebd_result_t'(m_tdata[25:0]);
			reports_checked++;
			if (awaited_reports.size() == 0) begin
				$display("%0t ns: report with nothing awaited, expected none, actual %h",
					$time, got_report);
				errors++;
			end else begin
				want_report = awaited_reports.pop_front();
				check_field("detent_count", int'($signed(want_report.detent_count)),
					int'($signed(got_report.detent_count)));
				check_field("enc_held", int'(want_report.enc_held),
					int'(got_report.enc_held));
				check_field("back_held", int'(want_report.back_held),
					int'(got_report.back_held));
				check_field("enc_short", int'(want_report.enc_short),
					int'(got_report.enc_short));
				check_field("back_short", int'(want_report.back_short),
					int'(got_report.back_short));
				check_field("enc_long", int'(want_report.enc_long),
					int'(got_report.enc_long));
				check_field("back_long", int'(want_report.back_long),
					int'(got_report.back_long));
				check_field("pin_levels", int'(want_report.pin_levels),
					int'(got_report.pin_levels));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t ns: timeout with %0d reports outstanding", $time,
				awaited_reports.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic push_sample(input logic a, b, en, bn, input logic [31:0] t,
			input logic cc, ce);
		ebd_pkg::ebd_item_t s;
		s.pins = {bn, en, b, a};
		s.time_ms = t;
		s.clear_count = cc;
		s.clear_events = ce;
		sample_queue.push_back(s);
	endtask

	function automatic logic [1:0] next_phase(logic [1:0] p, logic ccw);
		logic [1:0] n;
		if (ccw) begin
			case (p)
				2'd0: n = 2'd1;
				2'd1: n = 2'd3;
				2'd3: n = 2'd2;
				default: n = 2'd0;
			endcase
		end else begin
			case (p)
				2'd0: n = 2'd2;
				2'd2: n = 2'd3;
				2'd3: n = 2'd1;
				default: n = 2'd0;
			endcase
		end
		return n;
	endfunction

	// mostly clean rotation and button activity, with bounce and pin noise
	task automatic random_session(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				if ($urandom_range(0, 9) == 0)
					gen_ccw = !gen_ccw;
				gen_phase = next_phase(gen_phase, gen_ccw);
			end else if (r < 65) begin
				gen_phase = next_phase(gen_phase, !gen_ccw);
			end else if (r < 80) begin
				if ($urandom_range(0, 1))
					gen_enc_n = !gen_enc_n;
				else
					gen_back_n = !gen_back_n;
			end else if (r < 85) begin
				{gen_back_n, gen_enc_n, gen_phase} = 4'($urandom);
			end
			r = $urandom_range(0, 19);
			if (r == 0)
				gen_ms = $urandom;
			else if (r < 4)
				gen_ms += $urandom_range(200, 70000);
			else
				gen_ms += $urandom_range(0, 80);
			push_sample(gen_phase[1], gen_phase[0], gen_enc_n, gen_back_n, gen_ms,
				$urandom_range(0, 15) == 0, $urandom_range(0, 5) == 0);
		end
	endtask

	task automatic spin(int turns, logic ccw);
		repeat (4 * turns) begin
			gen_phase = next_phase(gen_phase, ccw);
			gen_ms++;
			push_sample(gen_phase[1], gen_phase[0], 1'b1, 1'b1, gen_ms, 1'b0, 1'b0);
		end
	endtask

	task automatic wait_drained();
		while (sample_queue.size() != 0 || s_tvalid || awaited_reports.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_long_press(logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		long_ms = v;
		@(negedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// buttons read as pressed at reset, so a first sample with them up is a release
		push_sample(1'b0, 1'b0, 1'b1, 1'b1, 32'd250, 1'b0, 1'b0);
		push_sample(1'b0, 1'b0, 1'b1, 1'b1, 32'd260, 1'b0, 1'b0);
		push_sample(1'b0, 1'b0, 1'b1, 1'b1, 32'd270, 1'b0, 1'b1);
		push_sample(1'b0, 1'b0, 1'b0, 1'b1, 32'd1000, 1'b0, 1'b0);
		push_sample(1'b0, 1'b0, 1'b1, 1'b1, 32'd1299, 1'b0, 1'b0);
		push_sample(1'b0, 1'b0, 1'b1, 1'b0, 32'd2000, 1'b0, 1'b0);
		push_sample(1'b0, 1'b0, 1'b1, 1'b1, 32'd2300, 1'b0, 1'b1);
		// press across the time wrap
		push_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFF0, 1'b0, 1'b0);
		push_sample(1'b0, 1'b0, 1'b1, 1'b1, 32'h0000_0020, 1'b0, 1'b1);
		push_sample(1'b0, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0);
		push_sample(1'b0, 1'b0, 1'b1, 1'b1, 32'h0000_012B, 1'b0, 1'b0);
		// clockwise detents, second one cleared after report
		push_sample(1'b1, 1'b0, 1'b1, 1'b1, 32'h0000_0130, 1'b0, 1'b1);
		push_sample(1'b1, 1'b1, 1'b1, 1'b1, 32'h0000_0131, 1'b0, 1'b0);
		push_sample(1'b0, 1'b1, 1'b1, 1'b1, 32'h0000_0132, 1'b0, 1'b0);
		push_sample(1'b0, 1'b0, 1'b1, 1'b1, 32'h0000_0133, 1'b0, 1'b0);
		push_sample(1'b1, 1'b0, 1'b1, 1'b1, 32'h0000_0134, 1'b0, 1'b0);
		push_sample(1'b1, 1'b1, 1'b0, 1'b1, 32'h0000_0135, 1'b0, 1'b0);
		push_sample(1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_0136, 1'b0, 1'b0);
		push_sample(1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0137, 1'b0, 1'b0);
		push_sample(1'b1, 1'b0, 1'b1, 1'b1, 32'h0000_0138, 1'b1, 1'b0);
		// counter-clockwise detent, then a bounce that must not count
		push_sample(1'b0, 1'b0, 1'b1, 1'b1, 32'h0000_0139, 1'b0, 1'b0);
		push_sample(1'b0, 1'b1, 1'b1, 1'b1, 32'h0000_013A, 1'b0, 1'b0);
		push_sample(1'b0, 1'b0, 1'b1, 1'b1, 32'h0000_013B, 1'b0, 1'b0);
		push_sample(1'b0, 1'b1, 1'b1, 1'b1, 32'h0000_013C, 1'b0, 1'b1);
		gen_phase = 2'd1;
		gen_ms = 32'h0000_0200;
		wait_drained();

		write_long_press(16'd0);
		idle_odds = 4;
		random_session(70);
		holds_asked++;
		wait_drained();

		write_long_press(16'hFFFF);
		idle_odds = 3;
		random_session(70);
		wait_drained();

		write_long_press(16'd1);
		idle_odds = 0;
		random_session(60);
		wait_drained();

		write_long_press(16'($urandom_range(2, 2000)));
		idle_odds = 6;
		random_session(100);
		wait_drained();

		write_long_press(ebd_pkg::LONG_PRESS_RESET);
		idle_odds = 4;
		random_session(50);
		holds_asked++;
		random_session(50);
		wait_drained();

		// steady spin both ways with no idling
		idle_odds = 0;
		spin(8, 1'b1);
		spin(8, 1'b0);
		wait_drained();
		repeat (8) @(posedge clk);

		$display("%0d reports checked over six press thresholds, %0d short and %0d long presses",
			reports_checked, short_presses, long_presses);
		$display("rotation both ways with bounce, time wrap and %0d receiver hold-offs",
			holds_asked);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/ebd_pkg.sv
rtl/ebd_update.sv
rtl/encoder_and_button_press_decoder_unit.sv
rtl/ebd_checker.sv
tb/sv/tb_encoder_and_button_press_decoder_unit.sv
